@@ src/smeu_pkg.sv @@
// ----------------------------------------------------------------------------
// smeu_pkg: shared types and codes of the stack machine execute unit
// Opcodes, op selectors, error codes and the word formats of both channels.
// ----------------------------------------------------------------------------
package smeu_pkg;

    localparam int MEM_WORDS_DEF = 4096;

    // opcodes
    localparam logic [6:0] OP_POP   = 7'd0;
    localparam logic [6:0] OP_IPOP  = 7'd1;
    localparam logic [6:0] OP_PUSH  = 7'd2;
    localparam logic [6:0] OP_IPUSH = 7'd3;
    localparam logic [6:0] OP_PUSHI = 7'd4;
    localparam logic [6:0] OP_JMP   = 7'd5;
    localparam logic [6:0] OP_JNZ   = 7'd6;
    localparam logic [6:0] OP_CALL  = 7'd7;
    localparam logic [6:0] OP_RET   = 7'd8;
    localparam logic [6:0] OP_READ  = 7'd9;
    localparam logic [6:0] OP_WRITE = 7'd10;
    localparam logic [6:0] OP_ALU   = 7'd11;
    localparam logic [6:0] OP_RND   = 7'd12;
    localparam logic [6:0] OP_DUP   = 7'd13;
    localparam logic [6:0] OP_HALT  = 7'd99;

    // selectors of the op instruction
    localparam logic [3:0] SEL_EQ  = 4'd0;
    localparam logic [3:0] SEL_NE  = 4'd1;
    localparam logic [3:0] SEL_GE  = 4'd2;
    localparam logic [3:0] SEL_LE  = 4'd3;
    localparam logic [3:0] SEL_GT  = 4'd4;
    localparam logic [3:0] SEL_LT  = 4'd5;
    localparam logic [3:0] SEL_OR  = 4'd6;
    localparam logic [3:0] SEL_XOR = 4'd7;
    localparam logic [3:0] SEL_AND = 4'd8;
    localparam logic [3:0] SEL_NOT = 4'd9;
    localparam logic [3:0] SEL_ADD = 4'd10;
    localparam logic [3:0] SEL_SUB = 4'd11;
    localparam logic [3:0] SEL_MUL = 4'd12;
    localparam logic [3:0] SEL_DIV = 4'd13;
    localparam logic [3:0] SEL_MOD = 4'd14;
    localparam logic [3:0] SEL_NEG = 4'd15;

    // error codes
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_ADDR  = 3'd1;
    localparam logic [2:0] E_UNDER = 3'd2;
    localparam logic [2:0] E_OVER  = 3'd3;
    localparam logic [2:0] E_SELF  = 3'd4;
    localparam logic [2:0] E_DIV0  = 3'd5;
    localparam logic [2:0] E_UNK   = 3'd6;

    typedef struct packed {
        logic [6:0]         mode;
        logic signed [15:0] operand;
        logic signed [15:0] read_value;
        logic [30:0]        random_sample;
    } instr_word_t;

    typedef struct packed {
        logic signed [15:0] next_pc;
        logic signed [15:0] written_value;
        logic               written_valid;
        logic [2:0]         error_code;
        logic               halted;
    } result_word_t;

endpackage

@@ src/smeu_stream_if.sv @@
// ----------------------------------------------------------------------------
// smeu_stream_if: valid/ready channel carrying one word
// The word type is set by the instantiating level.
// ----------------------------------------------------------------------------
interface smeu_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/stack_machine_execute_unit_top.sv @@
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_top: one instruction of a 16-bit stack machine
// Sequence: an accepted instruction word passes decode, two memory reads
//   and execute before the result word is valid; div, mod and rnd add the
//   bit-serial divider (one quotient bit per cycle, 31 bits) and a write.
// Throughput: one instruction at a time; a new word is taken only after
//   the result word is accepted. Single read port; shared divider.
// Reset: after rst_n rises a clearing pass writes zero to every memory word,
//   with instr.ready low; SP, PC and error latch reset to 0.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_top #(
    parameter int MEM_WORDS = smeu_pkg::MEM_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    smeu_stream_if.sink          instr,
    smeu_stream_if.source        result
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int SW = AW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DEC, S_RD1, S_RD2, S_EXEC, S_DIV, S_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        DK_DIV, DK_MOD, DK_RND
    } div_kind_t;

    state_t state_reg;

    // data memory: the stack grows upward from address 0
    logic [15:0]   mem [MEM_WORDS];
    logic [15:0]   rdata;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    // latched instruction word
    logic [6:0]   mode_reg;
    logic [15:0]  x_reg;
    logic [15:0]  rv_reg;
    logic [30:0]  rs_reg;
    logic [15:0]  d1_reg;
    logic [15:0]  d2_reg;

    // architectural state
    logic [SW-1:0] sp_reg;
    logic [15:0]   pc_reg;
    logic [2:0]    err_reg;
    logic [SW-1:0] clr_reg;

    smeu_pkg::result_word_t out_reg;

    // shared divider
    logic [16:0]   rem_reg;
    logic [30:0]   dvd_reg;
    logic [16:0]   dsr_reg;
    logic [4:0]    cnt_reg;
    div_kind_t     kind_reg;
    logic          neg_reg;
    logic [AW-1:0] daddr_reg;

    // ------------------------------------------------------------------------
    // memory: write port and registered read port
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[rd_addr];
    end

    // ------------------------------------------------------------------------
    // address helpers
    // ------------------------------------------------------------------------
    logic [SW-1:0] sp_m1;
    logic [SW-1:0] sp_m2;
    logic          sp_full;
    logic          x_ok;
    logic          n_ok;

    assign sp_m1   = sp_reg - SW'(1);
    assign sp_m2   = sp_reg - SW'(2);
    assign sp_full = (sp_reg == SW'(MEM_WORDS));
    assign x_ok    = !x_reg[15] && ({2'b00, x_reg[14:0]} < 17'(MEM_WORDS));
    assign n_ok    = !d1_reg[15] && ({2'b00, d1_reg[14:0]} < 17'(MEM_WORDS));

    // read address: first read issued in decode, second in the first read cycle
    always_comb
    begin
        rd_addr = sp_m1[AW-1:0];
        if (state_reg == S_DEC)
        begin
            if (mode_reg == smeu_pkg::OP_PUSH || mode_reg == smeu_pkg::OP_WRITE)
            begin
                rd_addr = x_reg[AW-1:0];
            end
        end
        else
        begin
            // ipush reads through the pointer on the stack top; ipop and op
            // read the word below it
            if (mode_reg == smeu_pkg::OP_IPUSH)
            begin
                rd_addr = rdata[AW-1:0];
            end
            else
            begin
                rd_addr = sp_m2[AW-1:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // execute: all checks and results from the two words read
    // ------------------------------------------------------------------------
    logic          ex_stop;
    logic [15:0]   pc1;
    logic [15:0]   pc_rel;
    logic [2:0]    ex_err;
    logic          ex_we;
    logic [AW-1:0] ex_waddr;
    logic [15:0]   ex_wdata;
    logic [SW-1:0] ex_sp;
    logic [15:0]   ex_pc;
    logic [15:0]   ex_wval;
    logic          ex_wvalid;
    logic          ex_div;
    div_kind_t     ex_kind;
    logic          ex_neg;
    logic [30:0]   ex_dvd;
    logic [16:0]   ex_dsr;
    logic [AW-1:0] ex_daddr;
    logic [15:0]   alu_a;
    logic [15:0]   alu_b;
    logic [15:0]   alu_r;
    logic [15:0]   a_abs;
    logic [15:0]   b_abs;
    logic          sel_ok;
    logic [31:0]   prod;

    assign ex_stop = (err_reg != smeu_pkg::E_NONE) || (mode_reg == smeu_pkg::OP_HALT);
    assign pc1     = pc_reg + 16'd1;
    assign pc_rel  = pc1 + x_reg;
    assign alu_a   = d2_reg;
    assign alu_b   = d1_reg;
    assign a_abs   = alu_a[15] ? (16'd0 - alu_a) : alu_a;
    assign b_abs   = alu_b[15] ? (16'd0 - alu_b) : alu_b;
    assign sel_ok  = (x_reg[15:4] == 12'd0);
    assign prod    = alu_a * alu_b;

    always_comb
    begin
        case (x_reg[3:0])
            smeu_pkg::SEL_EQ:  alu_r = 16'(alu_a == alu_b);
            smeu_pkg::SEL_NE:  alu_r = 16'(alu_a != alu_b);
            smeu_pkg::SEL_GE:  alu_r = 16'($signed(alu_a) >= $signed(alu_b));
            smeu_pkg::SEL_LE:  alu_r = 16'($signed(alu_a) <= $signed(alu_b));
            smeu_pkg::SEL_GT:  alu_r = 16'($signed(alu_a) > $signed(alu_b));
            smeu_pkg::SEL_LT:  alu_r = 16'($signed(alu_a) < $signed(alu_b));
            smeu_pkg::SEL_OR:  alu_r = alu_a | alu_b;
            smeu_pkg::SEL_XOR: alu_r = alu_a ^ alu_b;
            smeu_pkg::SEL_AND: alu_r = alu_a & alu_b;
            smeu_pkg::SEL_NOT: alu_r = ~d1_reg;
            smeu_pkg::SEL_ADD: alu_r = alu_a + alu_b;
            smeu_pkg::SEL_SUB: alu_r = alu_a - alu_b;
            smeu_pkg::SEL_MUL: alu_r = prod[15:0];
            smeu_pkg::SEL_NEG: alu_r = 16'd0 - d1_reg;
            default:           alu_r = 16'd0;
        endcase
    end

    always_comb
    begin
        ex_err    = smeu_pkg::E_NONE;
        ex_we     = 1'b0;
        ex_waddr  = sp_reg[AW-1:0];
        ex_wdata  = d1_reg;
        ex_sp     = sp_reg;
        ex_pc     = pc1;
        ex_wval   = 16'd0;
        ex_wvalid = 1'b0;
        ex_div    = 1'b0;
        ex_kind   = DK_DIV;
        ex_neg    = 1'b0;
        ex_dvd    = {15'd0, a_abs};
        ex_dsr    = {1'b0, b_abs};
        ex_daddr  = sp_m2[AW-1:0];
        unique case (mode_reg)
            smeu_pkg::OP_POP:
            begin
                if (!x_ok)
                    ex_err = smeu_pkg::E_ADDR;
                else if (sp_reg == '0)
                    ex_err = smeu_pkg::E_UNDER;
                else
                begin
                    ex_sp    = sp_m1;
                    ex_we    = 1'b1;
                    ex_waddr = x_reg[AW-1:0];
                end
            end
            smeu_pkg::OP_IPOP:
            begin
                if (sp_reg <= SW'(1))
                    ex_err = smeu_pkg::E_UNDER;
                else if (!n_ok)
                    ex_err = smeu_pkg::E_ADDR;
                else
                begin
                    ex_sp    = sp_m2;
                    ex_we    = 1'b1;
                    ex_waddr = d1_reg[AW-1:0];
                    ex_wdata = d2_reg;
                end
            end
            smeu_pkg::OP_PUSH:
            begin
                if (sp_full)
                    ex_err = smeu_pkg::E_OVER;
                else if (!x_ok)
                    ex_err = smeu_pkg::E_ADDR;
                else
                begin
                    ex_sp = sp_reg + SW'(1);
                    ex_we = 1'b1;
                end
            end
            smeu_pkg::OP_IPUSH:
            begin
                if (sp_reg == '0)
                    ex_err = smeu_pkg::E_UNDER;
                else if (!n_ok)
                    ex_err = smeu_pkg::E_ADDR;
                else
                begin
                    ex_we    = 1'b1;
                    ex_waddr = sp_m1[AW-1:0];
                    ex_wdata = d2_reg;
                end
            end
            smeu_pkg::OP_PUSHI:
            begin
                if (sp_full)
                    ex_err = smeu_pkg::E_OVER;
                else
                begin
                    ex_sp    = sp_reg + SW'(1);
                    ex_we    = 1'b1;
                    ex_wdata = x_reg;
                end
            end
            smeu_pkg::OP_JMP:
            begin
                if (x_reg == 16'hFFFF)
                    ex_err = smeu_pkg::E_SELF;
                else
                    ex_pc = pc_rel;
            end
            smeu_pkg::OP_JNZ:
            begin
                if (sp_reg == '0)
                    ex_err = smeu_pkg::E_UNDER;
                else
                begin
                    ex_sp = sp_m1;
                    if (d1_reg != 16'd0)
                    begin
                        if (x_reg == 16'hFFFF)
                            ex_err = smeu_pkg::E_SELF;
                        else
                            ex_pc = pc_rel;
                    end
                end
            end
            smeu_pkg::OP_CALL:
            begin
                if (sp_full)
                    ex_err = smeu_pkg::E_OVER;
                else if (x_reg == 16'hFFFF)
                    ex_err = smeu_pkg::E_SELF;
                else
                begin
                    ex_sp    = sp_reg + SW'(1);
                    ex_we    = 1'b1;
                    ex_wdata = pc1;
                    ex_pc    = pc_rel;
                end
            end
            smeu_pkg::OP_RET:
            begin
                if (sp_reg == '0)
                    ex_err = smeu_pkg::E_UNDER;
                else
                begin
                    ex_sp = sp_m1;
                    ex_pc = d1_reg;
                end
            end
            smeu_pkg::OP_READ:
            begin
                if (!x_ok)
                    ex_err = smeu_pkg::E_ADDR;
                else
                begin
                    ex_we    = 1'b1;
                    ex_waddr = x_reg[AW-1:0];
                    ex_wdata = rv_reg;
                end
            end
            smeu_pkg::OP_WRITE:
            begin
                if (!x_ok)
                    ex_err = smeu_pkg::E_ADDR;
                else
                begin
                    ex_wval   = d1_reg;
                    ex_wvalid = 1'b1;
                end
            end
            smeu_pkg::OP_ALU:
            begin
                if (sel_ok && (x_reg[3:0] == smeu_pkg::SEL_NOT ||
                               x_reg[3:0] == smeu_pkg::SEL_NEG))
                begin
                    if (sp_reg == '0)
                        ex_err = smeu_pkg::E_UNDER;
                    else
                    begin
                        ex_we    = 1'b1;
                        ex_waddr = sp_m1[AW-1:0];
                        ex_wdata = alu_r;
                    end
                end
                else if (sp_reg < SW'(2))
                    ex_err = smeu_pkg::E_UNDER;
                else if (!sel_ok)
                    ex_err = smeu_pkg::E_UNK;
                else if (x_reg[3:0] == smeu_pkg::SEL_DIV ||
                         x_reg[3:0] == smeu_pkg::SEL_MOD)
                begin
                    if (alu_b == 16'd0)
                        ex_err = smeu_pkg::E_DIV0;
                    else
                    begin
                        ex_sp   = sp_m1;
                        ex_div  = 1'b1;
                        ex_kind = (x_reg[3:0] == smeu_pkg::SEL_DIV) ? DK_DIV : DK_MOD;
                        ex_neg  = (x_reg[3:0] == smeu_pkg::SEL_DIV) ?
                                  (alu_a[15] ^ alu_b[15]) : alu_a[15];
                    end
                end
                else
                begin
                    ex_sp    = sp_m1;
                    ex_we    = 1'b1;
                    ex_waddr = sp_m2[AW-1:0];
                    ex_wdata = alu_r;
                end
            end
            smeu_pkg::OP_RND:
            begin
                if (sp_full)
                    ex_err = smeu_pkg::E_OVER;
                else
                begin
                    ex_sp    = sp_reg + SW'(1);
                    ex_div   = 1'b1;
                    ex_kind  = DK_RND;
                    ex_neg   = x_reg[15] || (x_reg == 16'd0);
                    ex_dvd   = rs_reg;
                    ex_daddr = sp_reg[AW-1:0];
                    if (x_reg == 16'd0)
                        ex_dsr = 17'd2;
                    else if (x_reg[15])
                        ex_dsr = 17'd2 - {x_reg[15], x_reg};
                    else
                        ex_dsr = {1'b0, x_reg};
                end
            end
            smeu_pkg::OP_DUP:
            begin
                if (sp_reg == '0)
                    ex_err = smeu_pkg::E_ADDR;
                else if (sp_full)
                    ex_err = smeu_pkg::E_OVER;
                else
                begin
                    ex_sp = sp_reg + SW'(1);
                    ex_we = 1'b1;
                end
            end
            default:
            begin
                ex_err = smeu_pkg::E_UNK;
            end
        endcase
        // an error leaves the stack and memory alone (jnz has already popped)
        if (ex_err != smeu_pkg::E_NONE)
        begin
            ex_we  = 1'b0;
            ex_div = 1'b0;
            ex_pc  = pc1;
            if (mode_reg != smeu_pkg::OP_JNZ)
                ex_sp = sp_reg;
        end
    end

    // ------------------------------------------------------------------------
    // divider step and final fix-up
    // ------------------------------------------------------------------------
    logic [17:0] div_sh;
    logic [17:0] div_diff;
    logic [15:0] div_base;
    logic [15:0] div_res;

    assign div_sh   = {rem_reg, dvd_reg[30]};
    assign div_diff = div_sh - {1'b0, dsr_reg};
    assign div_base = (kind_reg == DK_DIV) ? dvd_reg[15:0] : rem_reg[15:0];
    assign div_res  = neg_reg ? (16'd0 - div_base) : div_base;

    // write port: clearing pass, execute, or divide completion
    always_comb
    begin
        we      = 1'b0;
        wr_addr = ex_waddr;
        wr_data = ex_wdata;
        if (state_reg == S_CLEAR)
        begin
            we      = 1'b1;
            wr_addr = clr_reg[AW-1:0];
            wr_data = 16'd0;
        end
        else if (state_reg == S_FIN)
        begin
            we      = 1'b1;
            wr_addr = daddr_reg;
            wr_data = div_res;
        end
        else if (state_reg == S_EXEC && !ex_stop)
        begin
            we = ex_we;
        end
    end

    assign instr.ready    = (state_reg == S_IDLE);
    assign result.valid   = (state_reg == S_OUT);
    assign result.payload = out_reg;

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            pc_reg    <= '0;
            err_reg   <= smeu_pkg::E_NONE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    // sweep the memory to zero
                    clr_reg <= clr_reg + SW'(1);
                    if (clr_reg == SW'(MEM_WORDS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (instr.valid)
                    begin
                        mode_reg  <= instr.payload.mode;
                        x_reg     <= instr.payload.operand;
                        rv_reg    <= instr.payload.read_value;
                        rs_reg    <= instr.payload.random_sample;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    d1_reg    <= rdata;
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    d2_reg    <= rdata;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (ex_stop)
                    begin
                        // halt or latched error: change nothing
                        out_reg.next_pc       <= pc_reg;
                        out_reg.written_value <= 16'd0;
                        out_reg.written_valid <= 1'b0;
                        out_reg.error_code    <= err_reg;
                        out_reg.halted        <= 1'b1;
                        state_reg             <= S_OUT;
                    end
                    else
                    begin
                        sp_reg                <= ex_sp;
                        pc_reg                <= ex_pc;
                        err_reg               <= ex_err;
                        out_reg.next_pc       <= ex_pc;
                        out_reg.written_value <= ex_wval;
                        out_reg.written_valid <= ex_wvalid;
                        out_reg.error_code    <= ex_err;
                        out_reg.halted        <= (ex_err != smeu_pkg::E_NONE);
                        if (ex_div)
                        begin
                            rem_reg   <= '0;
                            dvd_reg   <= ex_dvd;
                            dsr_reg   <= ex_dsr;
                            kind_reg  <= ex_kind;
                            neg_reg   <= ex_neg;
                            daddr_reg <= ex_daddr;
                            cnt_reg   <= 5'd30;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_DIV:
                begin
                    // one restoring step per cycle, quotient shifts in low
                    if (!div_diff[17])
                        rem_reg <= div_diff[16:0];
                    else
                        rem_reg <= div_sh[16:0];
                    dvd_reg <= {dvd_reg[29:0], !div_diff[17]};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (result.ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_sp_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SW'(MEM_WORDS))
        else $error("stack pointer beyond memory size");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != smeu_pkg::E_NONE) |=> $stable(err_reg) && $stable(pc_reg))
        else $error("latched error or PC changed after an error");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !instr.ready)
        else $error("instruction taken while a result word waits");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == 5'd0) |=> state_reg == S_FIN)
        else $error("divider did not finish on its last step");

endmodule
